@@ hdl/unicode_sentence_boundary_stream_unit_defines.svh @@
// Assertion macros shared by the sentence boundary stream unit.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef UNICODE_SENTENCE_BOUNDARY_STREAM_UNIT_DEFINES_SVH
`define UNICODE_SENTENCE_BOUNDARY_STREAM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Implication that must hold at every clock edge outside reset.
`define USBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define USBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define USBS_ASSERT_IMP(lbl, ante, cons, msg)
`define USBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/usbs_pkg.sv @@
package usbs_pkg;

  // Field and port widths.
  localparam int CLASS_W         = 4;
  localparam int RESULT_W        = 32;
  localparam int CFG_W           = 32;
  localparam int S_TDATA_W       = 8;
  localparam int M_TDATA_W       = 32;
  localparam int DEF_POS_WIDTH   = 32;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Sentence_Break property classes; the front maps the unused input code to Other, and CL_NONE marks no previous item.
  typedef enum logic [CLASS_W-1:0] {
    CL_OTHER   = 4'd0,
    CL_CR      = 4'd1,
    CL_LF      = 4'd2,
    CL_EXTEND  = 4'd3,
    CL_FORMAT  = 4'd4,
    CL_SEP     = 4'd5,
    CL_SP      = 4'd6,
    CL_LOWER   = 4'd7,
    CL_UPPER   = 4'd8,
    CL_OLETTER = 4'd9,
    CL_NUMERIC = 4'd10,
    CL_ATERM   = 4'd11,
    CL_STERM   = 4'd12,
    CL_CLOSE   = 4'd13,
    CL_SCONT   = 4'd14,
    CL_NONE    = 4'd15
  } class_t;

  // Phase of the terminator tail: terminator, then Close run, then Sp run.
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_TERM  = 2'd1,
    PH_CLOSE = 2'd2,
    PH_SP    = 2'd3
  } phase_t;

  typedef struct packed {
    logic   aterm;
    phase_t ph;
  } tail_t;

  // Up to two results caused by one item, in output order.
  typedef struct packed {
    logic [RESULT_W-1:0] pos0;
    logic                end0;
    logic [RESULT_W-1:0] pos1;
    logic                end1;
    logic                two;
  } bundle_t;

  function automatic logic is_para_sep(class_t c);
    return (c == CL_SEP) || (c == CL_CR) || (c == CL_LF);
  endfunction

  // Classes that settle an open search for a following Lower.
  function automatic logic decides_search(class_t c);
    return (c == CL_OLETTER) || (c == CL_UPPER) || is_para_sep(c) ||
           (c == CL_STERM) || (c == CL_ATERM);
  endfunction

  function automatic tail_t next_tail(tail_t st, class_t c);
    tail_t r;
    r = '{aterm: 1'b0, ph: PH_NONE};
    if (c == CL_ATERM) begin
      r = '{aterm: 1'b1, ph: PH_TERM};
    end else if (c == CL_STERM) begin
      r = '{aterm: 1'b0, ph: PH_TERM};
    end else if (c == CL_CLOSE && (st.ph == PH_TERM || st.ph == PH_CLOSE)) begin
      r = '{aterm: st.aterm, ph: PH_CLOSE};
    end else if (c == CL_SP && st.ph != PH_NONE) begin
      r = '{aterm: st.aterm, ph: PH_SP};
    end
    return r;
  endfunction

endpackage

@@ hdl/usbs_front.sv @@
module usbs_front
  import usbs_pkg::*;
#(
  parameter int POS_WIDTH = DEF_POS_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CLASS_W-1:0]   in_class,
  input  logic                 in_eot,
  output logic                 q_push,
  output bundle_t              q_data,
  input  logic                 q_full
);

  localparam int CMP_W = (POS_WIDTH > RESULT_W) ? POS_WIDTH : RESULT_W;

  logic [CFG_W-1:0]     report_after;
  logic [POS_WIDTH-1:0] position;
  class_t               prev_lit;
  class_t               prev_sig;
  class_t               before_sig;
  tail_t                tail;
  logic                 pend_valid;
  logic [POS_WIDTH-1:0] pend_pos;

  logic                 fire;
  class_t               c;
  logic                 ign;
  logic                 pend_gt;
  logic                 idx_gt;
  logic                 pend_emit;
  logic                 pend_keep;
  logic                 brk;
  logic                 set_pend;
  logic                 pend_valid_next;
  logic [POS_WIDTH-1:0] pend_pos_next;
  logic [POS_WIDTH-1:0] position_next;
  logic                 eot_pend_emit;
  logic [3:0]           cand_v;
  logic [3:0]           cand_e;
  logic [RESULT_W-1:0]  cand_p [4];
  logic [1:0]           sel_cnt;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;

  // Map the unused class code to Other.
  assign c   = (class_t'(in_class) == CL_NONE) ? CL_OTHER : class_t'(in_class);
  assign ign = (c == CL_EXTEND) || (c == CL_FORMAT);

  // Filter compares against the start register.
  assign pend_gt = CMP_W'(pend_pos) > CMP_W'(report_after);
  assign idx_gt  = CMP_W'(position) > CMP_W'(report_after);

  // Resolution of an open search for a following Lower.
  assign pend_emit = pend_valid && !ign && decides_search(c) && pend_gt;
  assign pend_keep = pend_valid && !(!ign && (c == CL_LOWER || decides_search(c)));

  // Boundary rules against the running context.
  always_comb begin
    brk      = 1'b0;
    set_pend = 1'b0;
    if (prev_lit != CL_NONE) begin
      priority if (prev_lit == CL_CR && c == CL_LF) begin
        brk = 1'b0;
      end else if (is_para_sep(prev_lit)) begin
        brk = 1'b1;
      end else if (ign) begin
        brk = 1'b0;
      end else if (prev_sig == CL_ATERM && c == CL_NUMERIC) begin
        brk = 1'b0;
      end else if (c == CL_UPPER && prev_sig == CL_ATERM &&
                   (before_sig == CL_UPPER || before_sig == CL_LOWER)) begin
        brk = 1'b0;
      end else if (tail.ph != PH_NONE) begin
        priority if (c == CL_SCONT || c == CL_STERM || c == CL_ATERM) begin
          brk = 1'b0;
        end else if (tail.ph != PH_SP && c == CL_CLOSE) begin
          brk = 1'b0;
        end else if (c == CL_SP || is_para_sep(c)) begin
          brk = 1'b0;
        end else if (tail.aterm && c == CL_LOWER) begin
          brk = 1'b0;
        end else if (tail.aterm && !decides_search(c)) begin
          set_pend = 1'b1;
        end else begin
          brk = 1'b1;
        end
      end else begin
        brk = 1'b0;
      end
    end
  end

  assign pend_valid_next = set_pend || pend_keep;
  assign pend_pos_next   = set_pend ? position : pend_pos;
  assign position_next   = (position == {POS_WIDTH{1'b1}}) ? position : position + 1'b1;
  assign eot_pend_emit   = in_eot && pend_valid_next && (set_pend ? idx_gt : pend_gt);

  // Result candidates in output order.
  always_comb begin
    cand_v    = {in_eot, eot_pend_emit, brk && idx_gt, pend_emit};
    cand_e    = 4'b1000;
    cand_p[0] = RESULT_W'(pend_pos);
    cand_p[1] = RESULT_W'(position);
    cand_p[2] = RESULT_W'(pend_pos_next);
    cand_p[3] = RESULT_W'(position_next);
  end

  // Keep the first two candidates.
  always_comb begin
    q_data  = '0;
    sel_cnt = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (sel_cnt == 2'd0) begin
          q_data.pos0 = cand_p[i];
          q_data.end0 = cand_e[i];
          sel_cnt     = 2'd1;
        end else if (sel_cnt == 2'd1) begin
          q_data.pos1 = cand_p[i];
          q_data.end1 = cand_e[i];
          sel_cnt     = 2'd2;
        end
      end
    end
    q_data.two = (sel_cnt == 2'd2);
  end

  assign q_push = fire && (sel_cnt != 2'd0);

  // Start register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_after <= '0;
    end else if (cfg_we) begin
      report_after <= cfg_wdata;
    end
  end

  // Running context; end of text returns it to the reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      prev_lit   <= CL_NONE;
      prev_sig   <= CL_NONE;
      before_sig <= CL_NONE;
      tail       <= '{aterm: 1'b0, ph: PH_NONE};
      pend_valid <= 1'b0;
      pend_pos   <= '0;
    end else if (fire) begin
      if (in_eot) begin
        position   <= '0;
        prev_lit   <= CL_NONE;
        prev_sig   <= CL_NONE;
        before_sig <= CL_NONE;
        tail       <= '{aterm: 1'b0, ph: PH_NONE};
        pend_valid <= 1'b0;
        pend_pos   <= '0;
      end else begin
        position   <= position_next;
        prev_lit   <= c;
        pend_valid <= pend_valid_next;
        pend_pos   <= pend_pos_next;
        if (!ign) begin
          before_sig <= prev_sig;
          prev_sig   <= c;
          tail       <= next_tail(tail, c);
        end
      end
    end
  end

endmodule

@@ hdl/usbs_queue.sv @@
`include "unicode_sentence_boundary_stream_unit_defines.svh"

module usbs_queue
  import usbs_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t rdata,
  output logic    valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `USBS_ASSERT_IMP(a_no_push_full, push, !full, "queue written while full")
  `USBS_ASSERT_IMP(a_no_pop_empty, pop, valid, "queue read while empty")

endmodule

@@ hdl/usbs_back.sv @@
`include "unicode_sentence_boundary_stream_unit_defines.svh"

module usbs_back
  import usbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  bundle_t              q_data,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  logic                out_valid;
  logic [RESULT_W-1:0] out_pos;
  logic                out_end;
  logic                out_last;
  logic                second_valid;
  logic [RESULT_W-1:0] second_pos;
  logic                second_end;
  logic                load;

  // The output register reloads when empty or when its item is taken.
  assign load  = !out_valid || m_tready;
  assign q_pop = load && !second_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      second_valid <= 1'b0;
    end else if (load) begin
      if (second_valid) begin
        out_valid    <= 1'b1;
        second_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid    <= 1'b1;
        second_valid <= q_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_valid) begin
        out_pos  <= second_pos;
        out_end  <= second_end;
        out_last <= 1'b1;
      end else if (q_valid) begin
        out_pos    <= q_data.pos0;
        out_end    <= q_data.end0;
        out_last   <= !q_data.two;
        second_pos <= q_data.pos1;
        second_end <= q_data.end1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_pos);
  assign m_tuser  = out_end;
  assign m_tlast  = out_last;

  `USBS_ASSERT_IMP(a_second_behind_first, second_valid, out_valid,
                   "second result held without a first on the output")
  `USBS_ASSERT_IMP(a_first_not_last, second_valid && out_valid, !out_last,
                   "first of two results marked last")
  `USBS_ASSERT_NEXT(a_second_follows, second_valid && out_valid && m_tready,
                    out_valid && out_last, "second result not sent after the first")

endmodule

@@ hdl/unicode_sentence_boundary_stream_unit.sv @@
// Channel   Direction  Ports                         Contents (low bit first)
// s_axis    in         tvalid tready tdata tlast     tdata: prop_class[3:0]; tlast: end_of_text
// m_axis    out        tvalid tready tdata tuser     tdata: break_pos[31:0];
//                      tlast                         tuser: is_text_end; tlast: last_of_run
// cfg       in         cfg_we cfg_wdata              report_after[31:0]
//
// The front accepts one item every cycle while the result queue has room.
// Each result is a separate transfer on m_axis, so an item that causes two
// results sends them one after the other; the queue absorbs such bursts.
// A result passes through the queue and the output register before it appears on m_axis.
// Reset is synchronous and clears the running state, queue and start register.
// Back pressure on m_axis fills the queue, which then lowers s_axis_tready.
module unicode_sentence_boundary_stream_unit
  import usbs_pkg::*;
#(
  parameter int POS_WIDTH   = DEF_POS_WIDTH,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // prop_class[3:0], zero fill
  input  logic                 s_axis_tlast,   // end_of_text
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // break_pos[31:0]
  output logic                 m_axis_tuser,   // is_text_end
  output logic                 m_axis_tlast    // last_of_run
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  bundle_t q_wdata;
  bundle_t q_rdata;

  usbs_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_class (s_axis_tdata[CLASS_W-1:0]),
    .in_eot   (s_axis_tlast),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  usbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  usbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata),
    .m_tuser (m_axis_tuser),
    .m_tlast (m_axis_tlast)
  );

endmodule
